// ===== src/sha512_pkg.sv =====
// Shared types and constants for the SHA-512/384 single-block hasher.
// Holds the queued block type, round constants and initial values.
// No dependencies.
package sha512_pkg;

   localparam int WORD_W     = 64;
   localparam int NUM_WORDS  = 16;
   localparam int NUM_ROUNDS = 80;
   localparam int NUM_VARS   = 8;

   localparam logic [3:0] LAST_WORD_IDX = 4'd15;
   localparam logic [6:0] LAST_ROUND    = 7'd79;

   // digest word index of the final output per variant
   localparam logic [2:0] LAST_OUT_512 = 3'd7;
   localparam logic [2:0] LAST_OUT_384 = 3'd5;

   localparam logic VARIANT_SHA512 = 1'b0;
   localparam logic VARIANT_SHA384 = 1'b1;

   typedef logic [WORD_W-1:0] word_type;

   // one complete padded block plus the variant in force when it closed
   typedef struct packed {
      logic                       variant;
      logic [NUM_WORDS-1:0][WORD_W-1:0] words;
   } block_type;

   localparam word_type IV_512 [0:NUM_VARS-1] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam word_type IV_384 [0:NUM_VARS-1] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
   };

   localparam word_type ROUND_K [0:NUM_ROUNDS-1] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   function automatic word_type iv_word(input logic variant, input logic [2:0] idx);
      iv_word = (variant == VARIANT_SHA384) ? IV_384[idx] : IV_512[idx];
   endfunction

endpackage

// ===== src/sha512_front.sv =====
// Front end: takes message words, collects one 1024-bit block and pushes it
// to the block queue together with the variant register. Uses sha512_pkg.
module sha512_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [63:0]           req_msg_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_hash_variant,
   input  logic                  q_full,
   output logic                  push_valid,
   output sha512_pkg::block_type push_data
);

   logic [3:0]                count_ff, count_in;
   logic                      variant_ff, variant_in;
   sha512_pkg::word_type      words_ff [0:14];
   logic                      accept;

   assign busy      = q_full;
   assign csr_ready = 1'b1;
   assign accept    = start & ~q_full;

   always_comb begin
      count_in   = accept ? count_ff + 4'd1 : count_ff;
      variant_in = (csr_valid & csr_ready) ? csr_hash_variant : variant_ff;
      push_valid = accept && (count_ff == sha512_pkg::LAST_WORD_IDX);
   end

   always_comb begin
      push_data.variant = variant_ff;
      for (int i = 0; i < 15; i++) begin
         push_data.words[i] = words_ff[i];
      end
      push_data.words[15] = req_msg_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         variant_ff <= sha512_pkg::VARIANT_SHA512;
      end else begin
         count_ff   <= count_in;
         variant_ff <= variant_in;
      end
   end

   // word 15 goes straight into the queue entry
   always_ff @(posedge clock) begin
      if (accept && (count_ff != sha512_pkg::LAST_WORD_IDX)) begin
         words_ff[count_ff] <= req_msg_word;
      end
   end

endmodule

// ===== src/sha512_queue.sv =====
// Two-entry block queue between the front end and the compression engine.
// Uses sha512_pkg for the block type.
module sha512_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  sha512_pkg::block_type push_data,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output sha512_pkg::block_type head_data
);

   sha512_pkg::block_type entries_ff [0:1];
   logic                  wr_ptr_ff, rd_ptr_ff;
   logic [1:0]            count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      count_in = count_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/sha512_engine.sv =====
// Back end: 80-round SHA-512 compression, one round per cycle, with a
// 16-word rolling message schedule; then emits the digest words one per
// cycle. Uses sha512_pkg.
module sha512_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  sha512_pkg::block_type head_data,
   output logic                  pop,
   output logic                  rsp_strobe,
   output logic [63:0]           rsp_digest_word,
   output logic                  rsp_last_word
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_OUT   = 2'd2;

   function automatic sha512_pkg::word_type rotr(input sha512_pkg::word_type x,
                                                 input int n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

   logic [1:0]           state_ff, state_in;
   logic [6:0]           round_ff, round_in;
   logic [2:0]           idx_ff, idx_in;
   logic                 variant_ff;
   sha512_pkg::word_type w_ff [0:15];
   sha512_pkg::word_type v_ff [0:7];
   sha512_pkg::word_type t1, t2, new_w, s0, s1, bs0, bs1, ch, maj, sum;
   logic                 last_out;
   logic                 strobe_ff;
   sha512_pkg::word_type digest_ff;
   logic                 last_ff;

   assign pop             = (state_ff == ST_IDLE) && head_valid;
   assign rsp_strobe      = strobe_ff;
   assign rsp_digest_word = digest_ff;
   assign rsp_last_word   = last_ff;

   // round datapath
   always_comb begin
      bs1 = rotr(v_ff[4], 14) ^ rotr(v_ff[4], 18) ^ rotr(v_ff[4], 41);
      ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      bs0 = rotr(v_ff[0], 28) ^ rotr(v_ff[0], 34) ^ rotr(v_ff[0], 39);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1  = v_ff[7] + bs1 + ch + sha512_pkg::ROUND_K[round_ff] + w_ff[0];
      t2  = bs0 + maj;
      s0  = rotr(w_ff[1], 1) ^ rotr(w_ff[1], 8) ^ (w_ff[1] >> 7);
      s1  = rotr(w_ff[14], 19) ^ rotr(w_ff[14], 61) ^ (w_ff[14] >> 6);
      new_w = w_ff[0] + s0 + w_ff[9] + s1;
   end

   // digest word: final working variable plus initial value
   always_comb begin
      sum      = v_ff[idx_ff] + sha512_pkg::iv_word(variant_ff, idx_ff);
      last_out = (idx_ff == ((variant_ff == sha512_pkg::VARIANT_SHA384)
                             ? sha512_pkg::LAST_OUT_384 : sha512_pkg::LAST_OUT_512));
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               state_in = ST_ROUND;
               round_in = '0;
            end
         end
         ST_ROUND: begin
            round_in = round_ff + 7'd1;
            if (round_ff == sha512_pkg::LAST_ROUND) begin
               state_in = ST_OUT;
               idx_in   = '0;
            end
         end
         ST_OUT: begin
            idx_in = idx_ff + 3'd1;
            if (last_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         round_ff  <= '0;
         idx_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         round_ff  <= round_in;
         idx_ff    <= idx_in;
         strobe_ff <= (state_ff == ST_OUT);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         variant_ff <= head_data.variant;
         for (int i = 0; i < 16; i++) begin
            w_ff[i] <= head_data.words[i];
         end
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= sha512_pkg::iv_word(head_data.variant, 3'(i));
         end
      end else if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= new_w;
         v_ff[7]  <= v_ff[6];
         v_ff[6]  <= v_ff[5];
         v_ff[5]  <= v_ff[4];
         v_ff[4]  <= v_ff[3] + t1;
         v_ff[3]  <= v_ff[2];
         v_ff[2]  <= v_ff[1];
         v_ff[1]  <= v_ff[0];
         v_ff[0]  <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT) begin
         digest_ff <= sum;
         last_ff   <= last_out;
      end
   end

endmodule

// ===== src/sha512_single_block_hash.sv =====
// Top level of the SHA-512/384 single-block hasher.
// Depends on sha512_pkg, sha512_front, sha512_queue and sha512_engine.
//
//  - Input: one 64-bit message word per transaction, taken at a rising edge
//    with start high and busy low. Sixteen words form one padded block,
//    word 0 first. Words may come every cycle while busy is low.
//  - Config: csr_hash_variant written when csr_valid and csr_ready are high
//    (csr_ready is always high). 0 = SHA-512 (8 digest words), 1 = SHA-384
//    (6 digest words). The value in force at the sixteenth word counts.
//  - Output: each digest word shows for one cycle with rsp_strobe high,
//    word 0 first, on consecutive cycles; rsp_last_word marks the final one.
//    The receiver has no back-pressure and must take every word.
//  - Order: the block enters the queue at the edge that takes the sixteenth
//    word; the engine pops it when idle, runs the rounds, then emits digests.
//  - Engine: it does one round per cycle and takes no new block until the
//    final digest word of the current one is out. A two-block queue lets the
//    next block be collected meanwhile; busy rises while both queue entries
//    are filled.
//  - Reset (synchronous, active high) clears word count, queue, engine state
//    and the variant register (SHA-512). Partial blocks are dropped.
module sha512_single_block_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_msg_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_hash_variant,
   output logic        rsp_strobe,
   output logic [63:0] rsp_digest_word,
   output logic        rsp_last_word
);

   sha512_pkg::block_type push_data, head_data;
   logic                  push_valid, q_full, head_valid, pop;

   // collects words into blocks
   sha512_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_msg_word     (req_msg_word),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_hash_variant (csr_hash_variant),
      .q_full           (q_full),
      .push_valid       (push_valid),
      .push_data        (push_data)
   );

   // decouples block collection from compression
   sha512_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // compression and digest output
   sha512_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_data       (head_data),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_digest_word (rsp_digest_word),
      .rsp_last_word   (rsp_last_word)
   );

   // digest words of one block come back to back
   a_words_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_word) |=> rsp_strobe)
      else $error("digest word sequence broken");

   // the strobe does not stay high past the final digest word
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_word) |=> !rsp_strobe)
      else $error("strobe right after last digest word");

   // a block only enters the queue when there is room
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_full)
      else $error("block queue overflow");

   // nothing comes out the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("strobe after reset");

endmodule
